FILE: rtl/gln_pkg.sv
// Package for the gradient L2 normalizer.
// Holds the result width, the unit length and the control word carried down the pipeline.
`default_nettype none
package gln_pkg;

  // Result fields are signed 16-bit; magnitudes never exceed UNIT_LEN.
  localparam int unsigned NORM_W   = 16;
  localparam int unsigned QUO_W    = 15;
  localparam logic [QUO_W-1:0] UNIT_LEN = 15'h7FFF;

  // Control word that travels beside the data in every stage.
  typedef struct packed {
    logic valid;
    logic zero_x;
    logic zero_y;
    logic neg_x;
    logic neg_y;
  } ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/gln_front.sv
// Front end of the gradient L2 normalizer: magnitudes, squares, sum of squares
// and the scaled target for each lane. Depends on gln_pkg.
`default_nettype none
module gln_front #(
  parameter int unsigned GRAD_WIDTH = 16,
  parameter int unsigned TW = 2 * GRAD_WIDTH + 33
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           en,
  input  wire                           in_valid,
  input  wire  [GRAD_WIDTH-1:0]         grad_x,
  input  wire  [GRAD_WIDTH-1:0]         grad_y,
  output gln_pkg::ctrl_t                ctrl_out,
  output logic [2*GRAD_WIDTH-1:0]       sum_sq,
  output logic [1:0][TW-1:0]            rem_out,
  output logic [1:0][TW-1:0]            prod_out
);

  localparam int unsigned SW = 2 * GRAD_WIDTH;

  gln_pkg::ctrl_t ctrl_a, ctrl_b;
  logic [GRAD_WIDTH-1:0] mag_x, mag_y;
  logic [SW-1:0]         sq_x, sq_y;
  logic [SW-1:0]         sum_c;
  logic [TW-1:0]         tgt_x, tgt_y, sq_x_ext, sq_y_ext, sum_ext;

  // Stage A: magnitudes and sign flags (most negative value wraps to 2^(W-1))
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_a.valid <= 1'b0;
    end else if (en) begin
      ctrl_a.valid <= in_valid;
    end
    if (en) begin
      ctrl_a.neg_x  <= grad_x[GRAD_WIDTH-1];
      ctrl_a.neg_y  <= grad_y[GRAD_WIDTH-1];
      ctrl_a.zero_x <= (grad_x == '0);
      ctrl_a.zero_y <= (grad_y == '0);
      mag_x <= grad_x[GRAD_WIDTH-1] ? (~grad_x + 1'b1) : grad_x;
      mag_y <= grad_y[GRAD_WIDTH-1] ? (~grad_y + 1'b1) : grad_y;
    end
  end

  // Stage B: squares
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_b.valid <= 1'b0;
    end else if (en) begin
      ctrl_b.valid <= ctrl_a.valid;
    end
    if (en) begin
      ctrl_b.neg_x  <= ctrl_a.neg_x;
      ctrl_b.neg_y  <= ctrl_a.neg_y;
      ctrl_b.zero_x <= ctrl_a.zero_x;
      ctrl_b.zero_y <= ctrl_a.zero_y;
      sq_x <= SW'(mag_x) * SW'(mag_x);
      sq_y <= SW'(mag_y) * SW'(mag_y);
    end
  end

  // Stage C: target T = 4*32767^2*g^2 = (g2<<32) - (g2<<18) + (g2<<2)
  assign sum_c    = sq_x + sq_y;
  assign sq_x_ext = TW'(sq_x);
  assign sq_y_ext = TW'(sq_y);
  assign sum_ext  = TW'(sum_c);
  assign tgt_x    = (sq_x_ext << 32) - (sq_x_ext << 18) + (sq_x_ext << 2);
  assign tgt_y    = (sq_y_ext << 32) - (sq_y_ext << 18) + (sq_y_ext << 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else if (en) begin
      ctrl_out.valid <= ctrl_b.valid;
    end
    if (en) begin
      ctrl_out.neg_x  <= ctrl_b.neg_x;
      ctrl_out.neg_y  <= ctrl_b.neg_y;
      ctrl_out.zero_x <= ctrl_b.zero_x;
      ctrl_out.zero_y <= ctrl_b.zero_y;
      sum_sq      <= sum_c;
      // start with q = 0, d = 2q-1 = -1: remainder T - S, product d*S = -S
      rem_out[0]  <= tgt_x - sum_ext;
      rem_out[1]  <= tgt_y - sum_ext;
      prod_out[0] <= '0 - sum_ext;
      prod_out[1] <= '0 - sum_ext;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/gln_cell.sv
// One cell of the normalizer chain: settles one quotient bit for both lanes.
// Keeps remainder T - d^2*S and product d*S updated with shifts and adds. Depends on gln_pkg.
`default_nettype none
module gln_cell #(
  parameter int unsigned GRAD_WIDTH = 16,
  parameter int unsigned TW = 2 * GRAD_WIDTH + 33,
  parameter int unsigned BIT = 14
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 en,
  input  gln_pkg::ctrl_t                      ctrl_in,
  input  wire  [2*GRAD_WIDTH-1:0]             sum_in,
  input  wire  [1:0][TW-1:0]                  rem_in,
  input  wire  [1:0][TW-1:0]                  prod_in,
  input  wire  [1:0][gln_pkg::QUO_W-1:0]      quo_in,
  output gln_pkg::ctrl_t                      ctrl_out,
  output logic [2*GRAD_WIDTH-1:0]             sum_out,
  output logic [1:0][TW-1:0]                  rem_out,
  output logic [1:0][TW-1:0]                  prod_out,
  output logic [1:0][gln_pkg::QUO_W-1:0]      quo_out
);

  logic signed [TW-1:0] sum_ext;
  logic signed [TW-1:0] delta [2];
  logic signed [TW-1:0] trial [2];
  logic [1:0]           take;

  assign sum_ext = $signed(TW'(sum_in));

  // Raising q by 2^BIT adds 2^(BIT+2)*d*S + 2^(2*BIT+2)*S to d^2*S
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      delta[i] = ($signed(prod_in[i]) <<< (BIT + 2)) + (sum_ext <<< (2 * BIT + 2));
      trial[i] = $signed(rem_in[i]) - delta[i];
      take[i]  = ~trial[i][TW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else if (en) begin
      ctrl_out.valid <= ctrl_in.valid;
    end
    if (en) begin
      ctrl_out.neg_x  <= ctrl_in.neg_x;
      ctrl_out.neg_y  <= ctrl_in.neg_y;
      ctrl_out.zero_x <= ctrl_in.zero_x;
      ctrl_out.zero_y <= ctrl_in.zero_y;
      sum_out <= sum_in;
      for (int i = 0; i < 2; i++) begin
        if (take[i]) begin
          rem_out[i]  <= trial[i];
          prod_out[i] <= $signed(prod_in[i]) + (sum_ext <<< (BIT + 1));
          quo_out[i]  <= quo_in[i] | (gln_pkg::QUO_W'(1) << BIT);
        end else begin
          rem_out[i]  <= rem_in[i];
          prod_out[i] <= prod_in[i];
          quo_out[i]  <= quo_in[i];
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/gradient_l2_normalize.sv
// Gradient L2 normalizer, top level.
// Uses gln_pkg, gln_front and a chain of gln_cell instances.
//
// Usage:
//  Input words arrive on s_tvalid/s_tready/s_tdata, one gradient pair each:
//  grad_x in the low GRAD_WIDTH bits, grad_y above it. Results leave on
//  m_tvalid/m_tready/m_tdata: norm_x in bits 15:0, norm_y in bits 31:16.
//  Each result is 32767*g/sqrt(gx^2+gy^2), rounded half away from zero;
//  a zero component (or a zero vector) gives zero.
//  The stages are magnitudes, squares, the sum and targets, 15 chain
//  cells (one quotient bit each), and the output register. The whole
//  pipeline advances together, so a new word is taken every cycle while
//  the output register is empty or being read.
//  When the receiver stalls, every stage holds and s_tready drops until
//  the held output word is taken; nothing is lost or repeated.
//  Reset (rst, synchronous, active high) clears all valid flags; data
//  registers are not reset. There is no configuration.
`default_nettype none
module gradient_l2_normalize #(
  parameter int unsigned GRAD_WIDTH = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   s_tvalid,
  output logic                                  s_tready,
  // fields from bit 0: grad_x, grad_y, zero padding
  input  wire  [((2*GRAD_WIDTH+7)/8)*8-1:0]     s_tdata,
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  // fields from bit 0: norm_x, norm_y
  output logic [2*gln_pkg::NORM_W-1:0]          m_tdata
);

  localparam int unsigned TW    = 2 * GRAD_WIDTH + 33;
  localparam int unsigned CELLS = gln_pkg::QUO_W;
  localparam int unsigned NW    = gln_pkg::NORM_W;

  logic en;
  gln_pkg::ctrl_t                     ctrl [CELLS+1];
  logic [2*GRAD_WIDTH-1:0]            sums [CELLS+1];
  logic [1:0][TW-1:0]                 rems [CELLS+1];
  logic [1:0][TW-1:0]                 prods [CELLS+1];
  logic [1:0][gln_pkg::QUO_W-1:0]     quos [CELLS+1];
  logic [NW-1:0]                      mag_x, mag_y, res_x, res_y;

  // Pipeline moves whenever the output register can take a word
  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;

  gln_front #(.GRAD_WIDTH(GRAD_WIDTH), .TW(TW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .grad_x   (s_tdata[GRAD_WIDTH-1:0]),
    .grad_y   (s_tdata[2*GRAD_WIDTH-1:GRAD_WIDTH]),
    .ctrl_out (ctrl[0]),
    .sum_sq   (sums[0]),
    .rem_out  (rems[0]),
    .prod_out (prods[0])
  );
  assign quos[0] = '0;

  // Chain of cells, most significant quotient bit first
  for (genvar c = 0; c < CELLS; c++) begin : g_cell
    gln_cell #(.GRAD_WIDTH(GRAD_WIDTH), .TW(TW), .BIT(CELLS - 1 - c)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctrl_in  (ctrl[c]),
      .sum_in   (sums[c]),
      .rem_in   (rems[c]),
      .prod_in  (prods[c]),
      .quo_in   (quos[c]),
      .ctrl_out (ctrl[c+1]),
      .sum_out  (sums[c+1]),
      .rem_out  (rems[c+1]),
      .prod_out (prods[c+1]),
      .quo_out  (quos[c+1])
    );
  end

  // Clamp, zero forcing and sign restore
  always_comb begin
    mag_x = (quos[CELLS][0] > gln_pkg::UNIT_LEN) ? NW'(gln_pkg::UNIT_LEN)
                                                  : NW'(quos[CELLS][0]);
    mag_y = (quos[CELLS][1] > gln_pkg::UNIT_LEN) ? NW'(gln_pkg::UNIT_LEN)
                                                  : NW'(quos[CELLS][1]);
    if (ctrl[CELLS].zero_x) begin
      res_x = '0;
    end else begin
      res_x = ctrl[CELLS].neg_x ? (~mag_x + 1'b1) : mag_x;
    end
    if (ctrl[CELLS].zero_y) begin
      res_y = '0;
    end else begin
      res_y = ctrl[CELLS].neg_y ? (~mag_y + 1'b1) : mag_y;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= ctrl[CELLS].valid;
    end
    if (en) begin
      m_tdata <= {res_y, res_x};
    end
  end

`ifndef SYNTH
  // Magnitudes are clamped, so the most negative code never appears
  a_no_min_x: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[NW-1:0] != {1'b1, {(NW-1){1'b0}}})
    else $error("norm_x reached most negative code");
  a_no_min_y: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2*NW-1:NW] != {1'b1, {(NW-1){1'b0}}})
    else $error("norm_y reached most negative code");
  // Input side is ready exactly when the pipeline advances
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("ready does not follow pipeline enable");
  // A zero component in the last cell yields a zero field next cycle
  a_zero_x: assert property (@(posedge clk) disable iff (rst)
    (en && ctrl[CELLS].valid && ctrl[CELLS].zero_x) |=> m_tdata[NW-1:0] == '0)
    else $error("zero component produced nonzero norm_x");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_gradient_l2_normalize.sv
// Testbench for gradient_l2_normalize: drives gradient pairs on the input stream.
// It predicts the rounded, unit-length result of each pair and checks every output word.
// Depends on gln_pkg and the RTL top level only.
`timescale 1ns / 100ps
`default_nettype none
module tb_gradient_l2_normalize;

  localparam int GW = 16;
  localparam int DW = ((2*GW+7)/8)*8;
  localparam int NW = gln_pkg::NORM_W;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [DW-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [2*NW-1:0] m_tdata;

  typedef struct packed {
    logic [NW-1:0] ny;
    logic [NW-1:0] nx;
  } norm_pair_t;

  norm_pair_t norm_q[$];
  int err_cnt = 0;
  int sent_cnt = 0;
  int got_cnt = 0;
  longint cyc = 0;

  gradient_l2_normalize #(.GRAD_WIDTH(GW)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Largest q with (2q-1)^2 * s <= (2*32767*g)^2, clamped to the unit length.
  function automatic logic [NW-1:0] scale_component(logic signed [GW-1:0] g,
                                                     logic [2*GW:0] s);
    logic [GW-1:0] mag;
    logic [127:0] target;
    logic [127:0] lhs;
    logic [63:0] b;
    int lo;
    int hi;
    int mid;
    int best;
    logic [NW-1:0] res;
    mag = g[GW-1] ? (~g + 1'b1) : g;
    if (mag == 0 || s == 0) return '0;
    b = 64'(2) * 64'(gln_pkg::UNIT_LEN) * 64'(mag);
    target = 128'(b) * 128'(b);
    lo = 1;
    hi = gln_pkg::UNIT_LEN;
    best = 0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      lhs = 128'(2*mid - 1) * 128'(2*mid - 1) * 128'(s);
      if (lhs <= target) begin
        best = mid;
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    if (best > gln_pkg::UNIT_LEN) best = gln_pkg::UNIT_LEN;
    res = NW'(best);
    return g[GW-1] ? (~res + 1'b1) : res;
  endfunction

  function automatic norm_pair_t predict_norm(logic signed [GW-1:0] gx,
                                              logic signed [GW-1:0] gy);
    logic [GW-1:0] ax;
    logic [GW-1:0] ay;
    logic [2*GW:0] s;
    norm_pair_t r;
    ax = gx[GW-1] ? (~gx + 1'b1) : gx;
    ay = gy[GW-1] ? (~gy + 1'b1) : gy;
    s = (2*GW+1)'(ax) * ax + (2*GW+1)'(ay) * ay;
    r.nx = scale_component(gx, s);
    r.ny = scale_component(gy, s);
    return r;
  endfunction

  // Send one gradient pair after a random gap; record its expected result.
  task automatic send_pair(logic [GW-1:0] gx, logic [GW-1:0] gy);
    int gap;
    gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= DW'({gy, gx});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    norm_q.push_back(predict_norm(gx, gy));
    sent_cnt++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (norm_q.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  task automatic test_directed();
    logic [GW-1:0] v[10];
    v = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001,
          16'h5555, 16'hAAAA, 16'h0003, 16'hFFFC};
    send_pair(16'h0000, 16'h0000);
    for (int i = 1; i < 10; i++) send_pair(v[i], v[(i*3) % 10]);
    // equal magnitudes, and a 3-4-5 triangle whose ratios are exact
    send_pair(16'h8000, 16'h8000);
    send_pair(16'h7FFF, 16'h8001);
    send_pair(16'd3, 16'd4);
    send_pair(-16'sd4, 16'd3);
    send_pair(16'h8000, 16'h0000);
    send_pair(16'h0000, 16'h8000);
    send_pair(16'h7FFF, 16'h0001);
    send_pair(16'h0001, 16'h7FFF);
  endtask

  task automatic test_random(int n);
    logic [GW-1:0] gx;
    logic [GW-1:0] gy;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: begin
          gx = GW'($urandom_range(0, 65535));
          gy = GW'($urandom_range(0, 65535));
        end
        1: begin
          gx = GW'($urandom_range(0, 15)) - 16'd8;
          gy = GW'($urandom_range(0, 15)) - 16'd8;
        end
        2: begin
          gx = GW'($urandom_range(0, 65535));
          gy = $urandom_range(0, 1) ? 16'h0000 : GW'($urandom_range(0, 65535)) >> 8;
        end
        default: begin
          gx = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
          gy = GW'($urandom_range(0, 65535));
        end
      endcase
      if ($urandom_range(0, 1)) send_pair(gx, gy);
      else send_pair(gy, gx);
    end
  endtask

  // Receiver: random stalls, compare each word against the oldest expectation.
  initial begin
    norm_pair_t exp_w;
    norm_pair_t got_w;
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, 19);
      if ($urandom_range(0, 2) == 0) stall = 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && !rst)) @(posedge clk);
      got_w = m_tdata;
      got_cnt++;
      if (norm_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got_w);
        err_cnt++;
      end else begin
        exp_w = norm_q.pop_front();
        if (got_w.nx !== exp_w.nx) begin
          $display("%0t: norm_x expected %h actual %h", $time, exp_w.nx, got_w.nx);
          err_cnt++;
        end
        if (got_w.ny !== exp_w.ny) begin
          $display("%0t: norm_y expected %h actual %h", $time, exp_w.ny, got_w.ny);
          err_cnt++;
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    drain_results();
    test_random(560);
    drain_results();
    test_random(570);
    drain_results();
    if (norm_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, norm_q.size());
      err_cnt++;
    end
    $display("Covered %0d gradient pairs (zero, extreme, small and random vectors);",
             sent_cnt);
    $display("%0d normalized words checked under random input gaps and output stalls.",
             got_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
